// ===== hw/rtl/swm_pkg.sv =====
package swm_pkg;

  localparam int WINDOW_MAX = 64;
  localparam int HASH_W     = 64;
  localparam int WSIZE_W    = 7;
  localparam int CNT_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SEEN_W     = $clog2(WINDOW_MAX + 1);

  localparam logic [WSIZE_W-1:0] WSIZE_RESET = WSIZE_W'(16);

  typedef struct packed {
    logic shift;   // take neighbor's word this cycle
    logic in_win;  // cell position lies inside the active window
  } swm_ctl_t;

  // window size clamped to [1, WINDOW_MAX]
  function automatic logic [SEEN_W-1:0] eff_w(input logic [WSIZE_W-1:0] ws);
    if (ws == '0) begin
      return SEEN_W'(1);
    end else if (int'(ws) > WINDOW_MAX) begin
      return SEEN_W'(WINDOW_MAX);
    end else begin
      return SEEN_W'(ws);
    end
  endfunction

endpackage

// ===== hw/rtl/swm_cell.sv =====
module swm_cell
  import swm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  swm_ctl_t          ctl,
  input  logic [HASH_W-1:0] hash_in,
  input  logic              valid_in,
  input  logic [HASH_W-1:0] pm_in,
  output logic [HASH_W-1:0] hash_out,
  output logic              valid_out,
  output logic [HASH_W-1:0] pm_out
);

  logic [HASH_W-1:0] hash_r;
  logic              valid_r;
  logic [HASH_W-1:0] pm_r;
  logic              take;

  // running minimum from upstream cells, this cell joins when valid and in window
  assign take = valid_r && ctl.in_win && (hash_r < pm_in);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.shift) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      hash_r <= hash_in;
    end
    pm_r <= take ? hash_r : pm_in;
  end

  assign hash_out  = hash_r;
  assign valid_out = valid_r;
  assign pm_out    = pm_r;

endmodule

// ===== hw/rtl/sliding_window_minimizer_top.sv =====
// Sliding-window minimizer.
// Input channel: in_kmer_hash with in_read_start / in_read_end flags, one
// word per k-mer. A word is taken when in_valid is high and in_stall low.
// Output channel: out_minimizer_hash and out_last_of_read, taken when
// out_valid is high and out_stall low. Zero or one result per input word.
// cfg_wr_en / cfg_wr_data write window_size (0 acts as 1, values above
// WINDOW_MAX act as WINDOW_MAX); write only while the block is idle.
// The window is a chain of WINDOW_MAX cells shifting one slot per word. The
// window minimum is a running minimum passed cell to cell, one cell per
// cycle, swept in S_SWEEP and then judged in the decide step (S_DONE);
// in_stall holds off new words until the block is back in S_IDLE.
// The result sits in an output register; while it waits under out_stall the
// next word is still taken, and only a second result blocks the decide step.
// Reset empties the window, clears the k-mer count and sets window_size 16.
module sliding_window_minimizer_top
  import swm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [HASH_W-1:0]  in_kmer_hash,
  input  logic               in_read_start,
  input  logic               in_read_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [HASH_W-1:0]  out_minimizer_hash,
  output logic               out_last_of_read,
  input  logic               cfg_wr_en,
  input  logic [WSIZE_W-1:0] cfg_wr_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_DONE
  } state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [SEEN_W-1:0]  seen_r;
  logic [SEEN_W-1:0]  seen_base;
  logic [WSIZE_W-1:0] wsize_r;
  logic [SEEN_W-1:0]  w_eff;
  logic               start_r;
  logic               end_r;
  logic [HASH_W-1:0]  hash_r;
  logic [HASH_W-1:0]  last_r;
  logic               out_valid_r;
  logic [HASH_W-1:0]  out_hash_r;
  logic               out_last_r;

  logic               accept;
  logic               emit;
  logic               load_out;
  logic [HASH_W-1:0]  result;
  logic [HASH_W-1:0]  minv;

  logic [HASH_W-1:0]     cell_hash [WINDOW_MAX];
  logic [HASH_W-1:0]     cell_pm   [WINDOW_MAX];
  logic [WINDOW_MAX-1:0] cell_valid;

  assign w_eff    = eff_w(wsize_r);
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign minv     = cell_pm[WINDOW_MAX-1];

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    swm_ctl_t          ctl;
    logic [HASH_W-1:0] h_in;
    logic              v_in;
    logic [HASH_W-1:0] p_in;

    assign ctl.shift  = accept;
    assign ctl.in_win = (SEEN_W'(i) < w_eff);

    if (i == 0) begin : g_head
      assign h_in = in_kmer_hash;
      assign v_in = 1'b1;
      assign p_in = '1;
    end else begin : g_body
      assign h_in = cell_hash[i-1];
      assign v_in = cell_valid[i-1] && !in_read_start;
      assign p_in = cell_pm[i-1];
    end

    swm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .hash_in   (h_in),
      .valid_in  (v_in),
      .pm_in     (p_in),
      .hash_out  (cell_hash[i]),
      .valid_out (cell_valid[i]),
      .pm_out    (cell_pm[i])
    );
  end

  assign seen_base = in_read_start ? '0 : seen_r;

  always_comb begin
    emit   = 1'b0;
    result = hash_r;
    if (start_r || end_r) begin
      emit = 1'b1;
    end else if ((seen_r >= w_eff) && (minv != last_r)) begin
      emit   = 1'b1;
      result = minv;
    end
  end

  // decide step hands its result to the output register
  assign load_out = (state_r == S_DONE) && emit && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      seen_r      <= '0;
      wsize_r     <= WSIZE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        wsize_r <= cfg_wr_data;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            start_r <= in_read_start;
            end_r   <= in_read_end;
            hash_r  <= in_kmer_hash;
            cnt_r   <= '0;
            seen_r  <= (seen_base < SEEN_W'(WINDOW_MAX)) ? seen_base + SEEN_W'(1)
                                                         : seen_base;
            state_r <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(WINDOW_MAX - 1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!emit) begin
            state_r <= S_IDLE;
          end else if (load_out) begin
            out_hash_r  <= result;
            out_last_r  <= end_r;
            last_r      <= result;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_minimizer_hash = out_hash_r;
  assign out_last_of_read   = out_last_r;

  // valid slots form one run from the newest slot
  a_valid_run: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_valid & ~{cell_valid[WINDOW_MAX-2:0], 1'b1}) == '0)
    else $error("window valid bits not contiguous");

  // k-mer count tracks the number of filled slots
  a_seen_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == int'(seen_r))
    else $error("k-mer count disagrees with window fill");

  // a result is only loaded by the decide step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside decide step");

endmodule
